/* rtl/i2cm_pkg.sv */
// i2cm_pkg: shared types and constants for the i2c master byte engine
// no dependencies; used by the channel interfaces and every rtl module
package i2cm_pkg;

  localparam int ACTION_W   = 3;
  localparam int BYTE_W     = 8;
  localparam int PHASE_W    = 16;
  localparam int TIMEOUT_W  = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // request action codes
  localparam logic [ACTION_W-1:0] ACT_NONE  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 1'd1;

  localparam logic [PHASE_W-1:0]   PHASE_TICKS_RST = 16'd4;
  localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 8'd0;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // active command, one-hot
  typedef enum logic [4:0] {
    CMD_IDLE  = 5'b00001,
    CMD_START = 5'b00010,
    CMD_STOP  = 5'b00100,
    CMD_WRITE = 5'b01000,
    CMD_READ  = 5'b10000
  } cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   tx_byte;
    logic                send_ack;
    logic                sda_in;
  } req_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_pull_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_seen;
    logic              timed_out;
  } res_t;

  typedef struct packed {
    logic [PHASE_W-1:0]   phase_ticks;
    logic [TIMEOUT_W-1:0] ack_timeout;
  } cfg_t;

endpackage

/* rtl/i2cm_if.sv */
// i2cm channel interfaces: request, result and configuration write channels
// depends on i2cm_pkg for field widths
interface i2cm_req_if;
  logic                           valid;
  logic                           ready;
  logic [i2cm_pkg::ACTION_W-1:0]  action;
  logic [i2cm_pkg::BYTE_W-1:0]    tx_byte;
  logic                           send_ack;
  logic                           sda_in;
  modport source (output valid, action, tx_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, action, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cm_res_if;
  logic                         valid;
  logic                         ready;
  logic                         scl_level;
  logic                         sda_pull_low;
  logic                         busy_res;
  logic                         done_res;
  logic [i2cm_pkg::BYTE_W-1:0]  rx_byte;
  logic                         ack_seen;
  logic                         timed_out;
  modport source (output valid, scl_level, sda_pull_low, busy_res, done_res, rx_byte,
                  ack_seen, timed_out, input ready);
  modport sink   (input valid, scl_level, sda_pull_low, busy_res, done_res, rx_byte,
                  ack_seen, timed_out, output ready);
endinterface

interface i2cm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [i2cm_pkg::CFG_IDX_W-1:0]   index;
  logic [i2cm_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/i2cm_cfg_regs.sv */
// i2cm_cfg_regs: phase length and ack timeout registers
// depends on i2cm_pkg and i2cm_cfg_if
module i2cm_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  i2cm_cfg_if.sink       cfg,
  output i2cm_pkg::cfg_t cfg_q
);
  import i2cm_pkg::*;

  logic [PHASE_W-1:0]   phase_ticks_r;
  logic [TIMEOUT_W-1:0] ack_timeout_r;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PHASE_TICKS: phase_ticks_r <= cfg.data[PHASE_W-1:0];
        REG_ACK_TIMEOUT: ack_timeout_r <= cfg.data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_q.phase_ticks = phase_ticks_r;
  assign cfg_q.ack_timeout = ack_timeout_r;

endmodule

/* rtl/i2cm_core.sv */
// i2cm_core: bus sequencer state and its one-tick next-state logic
// depends on i2cm_pkg; result is combinational from the current request
module i2cm_core #(
  parameter int DIVIDER_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  i2cm_pkg::req_t req,
  input  i2cm_pkg::cfg_t cfg_q,
  output i2cm_pkg::res_t res
);
  import i2cm_pkg::*;

  localparam logic [2:0] STEP0 = 3'd0;
  localparam logic [2:0] STEP1 = 3'd1;
  localparam logic [2:0] STEP2 = 3'd2;
  localparam logic [2:0] STEP3 = 3'd3;
  localparam logic [2:0] STEP4 = 3'd4;
  localparam logic [2:0] STEP_ACK_WAIT = 3'd5;

  cmd_t                    cmd_r, cmd_nxt;
  logic [2:0]              step_r, step_nxt;
  logic [3:0]              bit_r, bit_nxt;
  logic [BYTE_W-1:0]       shift_r, shift_nxt;
  logic [DIVIDER_BITS-1:0] cnt_r, cnt_nxt;
  logic [TIMEOUT_W-1:0]    wait_r, wait_nxt;
  logic                    scl_r, scl_nxt;
  logic                    sda_r, sda_nxt;
  logic                    ack_r, ack_nxt;
  logic                    tout_r, tout_nxt;
  logic                    choice_r, choice_nxt;
  logic [BYTE_W-1:0]       rx_r, rx_nxt;

  logic [DIVIDER_BITS-1:0] load_raw, load_val, cnt_dec;
  logic [3:0]              bit_inc;
  logic [TIMEOUT_W-1:0]    wait_inc;
  logic                    do_set, do_fin, done;
  logic [2:0]              tgt;

  // phase length, zero counts as one tick
  assign load_raw = DIVIDER_BITS'(cfg_q.phase_ticks);
  assign load_val = (load_raw == '0) ? DIVIDER_BITS'(1) : load_raw;
  assign cnt_dec  = (cnt_r != '0) ? cnt_r - DIVIDER_BITS'(1) : '0;
  assign bit_inc  = bit_r + 4'd1;
  assign wait_inc = wait_r + TIMEOUT_W'(1);

  always_comb begin
    cmd_nxt    = cmd_r;
    step_nxt   = step_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    cnt_nxt    = cnt_r;
    wait_nxt   = wait_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    ack_nxt    = ack_r;
    tout_nxt   = tout_r;
    choice_nxt = choice_r;
    rx_nxt     = rx_r;
    do_set     = 1'b0;
    do_fin     = 1'b0;
    done       = 1'b0;
    tgt        = STEP0;

    if (cmd_r == CMD_IDLE) begin
      if (req.action == ACT_START || req.action == ACT_STOP ||
          req.action == ACT_WRITE || req.action == ACT_READ) begin
        case (req.action)
          ACT_START: cmd_nxt = CMD_START;
          ACT_STOP:  cmd_nxt = CMD_STOP;
          ACT_WRITE: cmd_nxt = CMD_WRITE;
          default:   cmd_nxt = CMD_READ;
        endcase
        ack_nxt    = 1'b0;
        tout_nxt   = 1'b0;
        bit_nxt    = '0;
        wait_nxt   = '0;
        choice_nxt = req.send_ack;
        shift_nxt  = (req.action == ACT_WRITE) ? req.tx_byte : '0;
        do_set     = 1'b1;
      end
    end else if (cmd_r == CMD_WRITE && step_r == STEP_ACK_WAIT) begin
      if (!req.sda_in) begin
        ack_nxt = 1'b1;
        scl_nxt = 1'b0;
        do_fin  = 1'b1;
      end else if (cnt_dec != '0) begin
        cnt_nxt = cnt_dec;
      end else begin
        cnt_nxt = load_val;
        if (cfg_q.ack_timeout != '0) begin
          wait_nxt = wait_inc;
          if (wait_inc >= cfg_q.ack_timeout) begin
            tout_nxt = 1'b1;
            cmd_nxt  = CMD_STOP;
            do_set   = 1'b1;
          end
        end
      end
    end else begin
      cnt_nxt = cnt_dec;
      if (cnt_dec == '0) begin
        case (cmd_r)
          CMD_START, CMD_STOP: begin
            if (step_r == STEP0) begin
              do_set = 1'b1;
              tgt    = STEP1;
            end else begin
              do_fin = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (step_r == STEP2) begin
              shift_nxt = {shift_r[BYTE_W-2:0], 1'b0};
              bit_nxt   = bit_inc;
              do_set    = 1'b1;
              tgt       = (bit_inc < BITS_PER_BYTE) ? STEP0 : STEP3;
            end else if (step_r <= STEP4) begin
              do_set = 1'b1;
              tgt    = step_r + 3'd1;
            end else begin
              do_fin = 1'b1;
            end
          end
          CMD_READ: begin
            if (step_r == STEP1) begin
              bit_nxt = bit_inc;
              do_set  = 1'b1;
              tgt     = (bit_inc < BITS_PER_BYTE) ? STEP0 : STEP2;
            end else if (step_r < STEP4) begin
              do_set = 1'b1;
              tgt    = step_r + 3'd1;
            end else begin
              do_fin = 1'b1;
            end
          end
          default: do_fin = 1'b1;
        endcase
      end
    end

    // end of command
    if (do_fin) begin
      if (cmd_r == CMD_START) scl_nxt = 1'b0;
      if (cmd_r == CMD_READ)  rx_nxt  = shift_r;
      cmd_nxt  = CMD_IDLE;
      step_nxt = STEP0;
      done     = 1'b1;
    end

    // entry into a new step of the (possibly new) command
    if (do_set) begin
      step_nxt = tgt;
      cnt_nxt  = load_val;
      case (cmd_nxt)
        CMD_START: begin
          if (tgt == STEP0) begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b0;
          end else begin
            sda_nxt = 1'b1;
          end
        end
        CMD_STOP: begin
          if (tgt == STEP0) begin
            scl_nxt = 1'b0;
            sda_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b0;
          end
        end
        CMD_WRITE: begin
          if (tgt == STEP0) begin
            scl_nxt = 1'b0;
            sda_nxt = ~shift_nxt[BYTE_W-1];
          end else if (tgt == STEP1 || tgt == STEP4 || tgt == STEP_ACK_WAIT) begin
            scl_nxt = 1'b1;
          end else if (tgt == STEP2) begin
            scl_nxt = 1'b0;
          end else begin
            scl_nxt = 1'b0;
            sda_nxt = 1'b0;
          end
        end
        CMD_READ: begin
          if (tgt == STEP0) begin
            scl_nxt = 1'b0;
            sda_nxt = 1'b0;
          end else if (tgt == STEP1) begin
            scl_nxt   = 1'b1;
            shift_nxt = {shift_nxt[BYTE_W-2:0], req.sda_in};
          end else if (tgt == STEP2) begin
            scl_nxt = 1'b0;
            sda_nxt = choice_nxt;
          end else if (tgt == STEP3) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r    <= CMD_IDLE;
      step_r   <= STEP0;
      bit_r    <= '0;
      shift_r  <= '0;
      cnt_r    <= '0;
      wait_r   <= '0;
      scl_r    <= 1'b1;
      sda_r    <= 1'b0;
      ack_r    <= 1'b0;
      tout_r   <= 1'b0;
      choice_r <= 1'b0;
      rx_r     <= '0;
    end else if (step_en) begin
      cmd_r    <= cmd_nxt;
      step_r   <= step_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      cnt_r    <= cnt_nxt;
      wait_r   <= wait_nxt;
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
      ack_r    <= ack_nxt;
      tout_r   <= tout_nxt;
      choice_r <= choice_nxt;
      rx_r     <= rx_nxt;
    end
  end

  assign res.scl_level    = scl_nxt;
  assign res.sda_pull_low = sda_nxt;
  assign res.busy_res     = (cmd_nxt != CMD_IDLE);
  assign res.done_res     = done;
  assign res.rx_byte      = rx_nxt;
  assign res.ack_seen     = ack_nxt;
  assign res.timed_out    = tout_nxt;

endmodule

/* rtl/i2c_master_byte_engine.sv */
// i2c_master_byte_engine: top level, request register, sequencer and result register
// depends on i2cm_pkg, i2cm_if, i2cm_cfg_regs and i2cm_core
//
// usage:
//   in_req carries one timer tick per request: action (none, start, stop, write
//   byte, read byte), tx_byte, send_ack and the sampled sda level
//   out_res returns exactly one result per request: scl and sda drive levels,
//   busy, a done pulse, the last read byte, ack seen and timed out
//   cfg_wr writes phase_ticks (index 0) and ack_timeout (index 1); write it
//   only while no command is running and all results have been taken
// timing:
//   a request is registered on acceptance and stepped through the sequencer
//   on the next edge where the result register is free; its result is
//   written into the result register at that same edge
//   one request per cycle is taken back to back while out_res.ready is high, set
//   by the single pass of sequencer logic between the request and result registers
// reset (rst_n low, synchronous): sequencer idle, scl released, sda released,
//   registers back to phase_ticks 4 and ack_timeout 0, both channels empty
// stall: when out_res.ready is low and a result is held, it stays; a request is
//   taken into the request register only if that is empty, then in_req.ready drops
module i2c_master_byte_engine #(
  parameter int DIVIDER_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  i2cm_req_if.sink  in_req,
  i2cm_res_if.source out_res,
  i2cm_cfg_if.sink  cfg_wr
);
  import i2cm_pkg::*;

  logic   req_valid_r;
  req_t   req_r;
  logic   res_valid_r;
  res_t   res_r;
  res_t   res_nxt;
  cfg_t   cfg_q;
  logic   step_en;
  logic   in_fire;

  // sequencer advances when a request waits and the result slot frees up
  assign step_en       = req_valid_r && (!res_valid_r || out_res.ready);
  assign in_req.ready  = !req_valid_r || step_en;
  assign in_fire       = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_fire) begin
      req_valid_r <= 1'b1;
    end else if (step_en) begin
      req_valid_r <= 1'b0;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.action   <= in_req.action;
      req_r.tx_byte  <= in_req.tx_byte;
      req_r.send_ack <= in_req.send_ack;
      req_r.sda_in   <= in_req.sda_in;
    end
  end

  i2cm_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_wr),
    .cfg_q (cfg_q)
  );

  i2cm_core #(
    .DIVIDER_BITS (DIVIDER_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .req     (req_r),
    .cfg_q   (cfg_q),
    .res     (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (step_en) begin
      res_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid        = res_valid_r;
  assign out_res.scl_level    = res_r.scl_level;
  assign out_res.sda_pull_low = res_r.sda_pull_low;
  assign out_res.busy_res     = res_r.busy_res;
  assign out_res.done_res     = res_r.done_res;
  assign out_res.rx_byte      = res_r.rx_byte;
  assign out_res.ack_seen     = res_r.ack_seen;
  assign out_res.timed_out    = res_r.timed_out;

endmodule

/* tb/sv/tb_i2c_master_byte_engine.sv */
`timescale 1ns / 1ps
// tb_i2c_master_byte_engine: self-checking bench for the i2c master byte engine
// drives timer-tick requests, predicts every result in order and compares them
// depends on i2cm_pkg, the i2cm channel interfaces and i2c_master_byte_engine
module tb_i2c_master_byte_engine;
  import i2cm_pkg::*;

  // watchdog: cycles with no handshake on any channel before giving up
  localparam int WATCHDOG_LIMIT = 2000;
  // ack delay meaning "slave never pulls sda low"
  localparam int NO_ACK         = 100000;
  // ack delay cap when the engine would otherwise wait forever
  localparam int ACK_DELAY_CAP  = 40;
  // action codes outside the defined set, ignored like none
  localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = ACT_READ + 3'd1;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;
  localparam int RANDOM_TICKS   = 500;
  // divider for the closing no-gap run
  localparam logic [PHASE_W-1:0] SLOW_PHASE = 16'd24;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  i2cm_req_if in_req();
  i2cm_res_if out_res();
  i2cm_cfg_if cfg_wr();

  i2c_master_byte_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_res(out_res),
    .cfg_wr (cfg_wr)
  );

  // ---------------------------------------------------------------------------
  // line engine model state: our own copy of registers and sequencer
  // ---------------------------------------------------------------------------
  logic [PHASE_W-1:0]   cfg_phase;
  logic [TIMEOUT_W-1:0] cfg_timeout;

  cmd_t               eng_cmd;
  logic [3:0]         eng_step;
  logic [3:0]         eng_bits;
  logic [BYTE_W-1:0]  eng_shift;
  logic [PHASE_W-1:0] eng_phase;
  logic [7:0]         eng_waits;
  logic               eng_scl;
  logic               eng_sda;
  logic               eng_ack;
  logic               eng_tmo;
  logic               eng_sack;
  logic [BYTE_W-1:0]  eng_rx;
  logic               eng_done;

  // results still owed by the engine, oldest first
  res_t expected_results[$];

  int tick_count  = 0;
  int result_count = 0;
  int mismatches  = 0;
  int ack_hold    = 0;
  int stall_left  = 0;
  int idle_cycles = 0;
  bit idle_on     = 1'b1;

  res_t got_res;
  res_t want_res;

  function automatic void reset_engine_model();
    cfg_phase   = PHASE_TICKS_RST;
    cfg_timeout = ACK_TIMEOUT_RST;
    eng_cmd     = CMD_IDLE;
    eng_step    = '0;
    eng_bits    = '0;
    eng_shift   = '0;
    eng_phase   = '0;
    eng_waits   = '0;
    eng_scl     = 1'b1;
    eng_sda     = 1'b0;
    eng_ack     = 1'b0;
    eng_tmo     = 1'b0;
    eng_sack    = 1'b0;
    eng_rx      = '0;
    eng_done    = 1'b0;
  endfunction

  // a zero divider still lasts one tick
  function automatic logic [PHASE_W-1:0] phase_len();
    return (cfg_phase == '0) ? PHASE_W'(1) : cfg_phase;
  endfunction

  function automatic cmd_t cmd_of(input logic [ACTION_W-1:0] act);
    case (act)
      ACT_START: return CMD_START;
      ACT_STOP:  return CMD_STOP;
      ACT_WRITE: return CMD_WRITE;
      ACT_READ:  return CMD_READ;
      default:   return CMD_IDLE;
    endcase
  endfunction

  function automatic void end_command();
    if (eng_cmd == CMD_START) eng_scl = 1'b0;
    if (eng_cmd == CMD_READ) eng_rx = eng_shift;
    eng_cmd  = CMD_IDLE;
    eng_step = '0;
    eng_done = 1'b1;
  endfunction

  // enter a phase: set the line levels it holds and reload the divider
  function automatic void enter_phase(input logic [3:0] s, input logic sda);
    eng_step  = s;
    eng_phase = phase_len();
    case (eng_cmd)
      CMD_START: begin
        if (s == 4'd0) begin
          eng_scl = 1'b1;
          eng_sda = 1'b0;
        end else begin
          eng_sda = 1'b1;
        end
      end
      CMD_STOP: begin
        if (s == 4'd0) begin
          eng_scl = 1'b0;
          eng_sda = 1'b1;
        end else begin
          eng_scl = 1'b1;
          eng_sda = 1'b0;
        end
      end
      CMD_WRITE: begin
        // data bit: a one releases sda, a zero pulls it low
        if (s == 4'd0) begin
          eng_scl = 1'b0;
          eng_sda = ~eng_shift[BYTE_W-1];
        end else if (s == 4'd1 || s == 4'd4 || s == 4'd5) begin
          eng_scl = 1'b1;
        end else if (s == 4'd2) begin
          eng_scl = 1'b0;
        end else begin
          eng_scl = 1'b0;
          eng_sda = 1'b0;
        end
      end
      CMD_READ: begin
        if (s == 4'd0) begin
          eng_scl = 1'b0;
          eng_sda = 1'b0;
        end else if (s == 4'd1) begin
          eng_scl   = 1'b1;
          eng_shift = {eng_shift[BYTE_W-2:0], sda};
        end else if (s == 4'd2) begin
          eng_scl = 1'b0;
          eng_sda = eng_sack;
        end else if (s == 4'd3) begin
          eng_scl = 1'b1;
        end else begin
          eng_scl = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void phase_done(input logic sda);
    case (eng_cmd)
      CMD_START, CMD_STOP: begin
        if (eng_step == 4'd0) enter_phase(4'd1, sda);
        else end_command();
      end
      CMD_WRITE: begin
        if (eng_step == 4'd2) begin
          eng_shift = eng_shift << 1;
          eng_bits  = eng_bits + 4'd1;
          enter_phase((eng_bits < BITS_PER_BYTE) ? 4'd0 : 4'd3, sda);
        end else if (eng_step <= 4'd4) begin
          enter_phase(eng_step + 4'd1, sda);
        end else begin
          end_command();
        end
      end
      CMD_READ: begin
        if (eng_step == 4'd1) begin
          eng_bits = eng_bits + 4'd1;
          enter_phase((eng_bits < BITS_PER_BYTE) ? 4'd0 : 4'd2, sda);
        end else if (eng_step < 4'd4) begin
          enter_phase(eng_step + 4'd1, sda);
        end else begin
          end_command();
        end
      end
      default: end_command();
    endcase
  endfunction

  // scl held high until the slave pulls sda low, or the timeout runs out
  function automatic void ack_wait(input logic sda);
    if (!sda) begin
      eng_ack = 1'b1;
      eng_scl = 1'b0;
      end_command();
      return;
    end
    if (eng_phase != '0) eng_phase = eng_phase - PHASE_W'(1);
    if (eng_phase != '0) return;
    eng_phase = phase_len();
    if (cfg_timeout != '0) begin
      eng_waits = eng_waits + 8'd1;
      if (eng_waits >= cfg_timeout) begin
        eng_tmo = 1'b1;
        eng_cmd = CMD_STOP;
        enter_phase(4'd0, sda);
      end
    end
  endfunction

  // one timer tick through the engine; returns the line state after it
  function automatic res_t advance_engine(input logic [ACTION_W-1:0] act,
                                          input logic [BYTE_W-1:0]   txb,
                                          input logic                sack,
                                          input logic                sda);
    res_t r;
    eng_done = 1'b0;
    if (eng_cmd == CMD_IDLE) begin
      if (act >= ACT_START && act <= ACT_READ) begin
        eng_cmd   = cmd_of(act);
        eng_ack   = 1'b0;
        eng_tmo   = 1'b0;
        eng_bits  = '0;
        eng_waits = '0;
        eng_sack  = sack;
        eng_shift = (act == ACT_WRITE) ? txb : '0;
        enter_phase(4'd0, sda);
      end
    end else if (eng_cmd == CMD_WRITE && eng_step == 4'd5) begin
      ack_wait(sda);
    end else begin
      if (eng_phase != '0) eng_phase = eng_phase - PHASE_W'(1);
      if (eng_phase == '0) phase_done(sda);
    end
    r.scl_level    = eng_scl;
    r.sda_pull_low = eng_sda;
    r.busy_res     = (eng_cmd != CMD_IDLE);
    r.done_res     = eng_done;
    r.rx_byte      = eng_rx;
    r.ack_seen     = eng_ack;
    r.timed_out    = eng_tmo;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: called at a falling edge, returns at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_tick(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] txb,
                           input logic sack, input logic sda);
    // random gap before the request
    if (idle_on && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 16)) @(negedge clk);
    in_req.valid    = 1'b1;
    in_req.action   = act;
    in_req.tx_byte  = txb;
    in_req.send_ack = sack;
    in_req.sda_in   = sda;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    // request accepted at this edge
    expected_results.push_back(advance_engine(act, txb, sack, sda));
    tick_count++;
    @(negedge clk);
    in_req.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr.valid = 1'b1;
    cfg_wr.index = idx;
    cfg_wr.data  = value;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    if (idx == REG_PHASE_TICKS) cfg_phase = value[PHASE_W-1:0];
    else cfg_timeout = value[TIMEOUT_W-1:0];
    @(negedge clk);
    cfg_wr.valid = 1'b0;
  endtask

  // keep ticking while a command runs; the slave acks after ack_delay wait ticks
  task automatic drive_busy(input int ack_delay);
    logic sda;
    while (eng_cmd != CMD_IDLE) begin
      if (eng_cmd == CMD_WRITE && eng_step == 4'd5) begin
        sda = (ack_hold >= ack_delay) ? 1'b0 : 1'b1;
        ack_hold++;
      end else begin
        sda      = 1'($urandom_range(0, 1));
        ack_hold = 0;
      end
      // any action while busy must be ignored, so throw in random ones
      send_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)), sda);
    end
  endtask

  task automatic run_cmd(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] txb,
                         input logic sack, input int ack_delay);
    int delay;
    // with no timeout the slave must ack eventually
    delay    = (cfg_timeout == '0 && ack_delay > ACK_DELAY_CAP) ? ACK_DELAY_CAP : ack_delay;
    ack_hold = 0;
    send_tick(act, txb, sack, 1'($urandom_range(0, 1)));
    drive_busy(delay);
  endtask

  // engine idle and every result taken before a register write
  task automatic settle();
    drive_busy(0);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input logic [PHASE_W-1:0] phase, input logic [TIMEOUT_W-1:0] tmo);
    logic [CFG_DATA_W-1:0] tmo_word;
    settle();
    // upper bits of the timeout word are don't-care
    tmo_word = {8'($urandom), tmo};
    if ($urandom_range(0, 1)) begin
      write_reg(REG_PHASE_TICKS, phase);
      write_reg(REG_ACK_TIMEOUT, tmo_word);
    end else begin
      write_reg(REG_ACK_TIMEOUT, tmo_word);
      write_reg(REG_PHASE_TICKS, phase);
    end
  endtask

  function automatic int pick_ack_delay();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 3);
    if (r < 9) return $urandom_range(4, 12);
    return NO_ACK;
  endfunction

  // a few idle ticks with none or an unused action code
  task automatic idle_gap();
    repeat ($urandom_range(0, 3))
      send_tick(($urandom_range(0, 3) == 0) ? ACT_NONE :
                3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST)),
                8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset line state, then none and unused actions leave the engine idle
  task automatic test_idle_ticks();
    repeat (2) send_tick(ACT_NONE, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
    for (int a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++)
      send_tick(3'(a), 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // every command at the reset divider, byte extremes and both ack choices
  task automatic test_bus_sequences();
    run_cmd(ACT_START, 8'($urandom), 1'b0, 0);
    run_cmd(ACT_WRITE, 8'h00, 1'b0, 0);
    run_cmd(ACT_WRITE, 8'hFF, 1'b1, 3);
    run_cmd(ACT_WRITE, 8'hA5, 1'b0, 9);
    // read with ack: sda stays pulled low through the idle ticks
    run_cmd(ACT_READ, 8'hFF, 1'b1, 0);
    repeat (2) send_tick(ACT_NONE, 8'h00, 1'b0, 1'b1);
    run_cmd(ACT_READ, 8'h00, 1'b0, 0);
    // repeated start, then stop twice
    run_cmd(ACT_START, 8'($urandom), 1'b1, 0);
    run_cmd(ACT_STOP, 8'($urandom), 1'b0, 0);
    run_cmd(ACT_STOP, 8'($urandom), 1'b1, 0);
  endtask

  // a zero divider counts as one tick per phase
  task automatic test_zero_phase();
    set_config('0, '0);
    run_cmd(ACT_START, 8'h00, 1'b0, 0);
    run_cmd(ACT_WRITE, 8'h5A, 1'b0, 1);
    run_cmd(ACT_READ, 8'h00, 1'b1, 0);
    run_cmd(ACT_READ, 8'h00, 1'b0, 0);
    run_cmd(ACT_STOP, 8'h00, 1'b0, 0);
  endtask

  // ack wait running out issues a stop; flags clear on the next command
  task automatic test_ack_timeout();
    set_config(16'd2, 8'd3);
    run_cmd(ACT_START, 8'h00, 1'b0, 0);
    run_cmd(ACT_WRITE, 8'h3C, 1'b0, NO_ACK);
    run_cmd(ACT_START, 8'h00, 1'b0, 0);
    run_cmd(ACT_WRITE, 8'hC3, 1'b0, 2);
    run_cmd(ACT_STOP, 8'h00, 1'b0, 0);
    // longest timeout at the shortest divider
    set_config(16'd1, 8'd255);
    run_cmd(ACT_WRITE, 8'h81, 1'b0, NO_ACK);
    run_cmd(ACT_WRITE, 8'h7E, 1'b0, 200);
    set_config(16'd3, 8'd1);
    run_cmd(ACT_WRITE, 8'h18, 1'b1, NO_ACK);
    run_cmd(ACT_READ, 8'h00, 1'b1, 0);
    run_cmd(ACT_STOP, 8'h00, 1'b0, 0);
  endtask

  // start, writes, reads, stop with random content and settings, plus noise
  task automatic run_transaction();
    int n_wr;
    int n_rd;
    bit aborted;
    n_wr    = $urandom_range(1, 3);
    n_rd    = $urandom_range(0, 2);
    aborted = 1'b0;
    run_cmd(ACT_START, 8'($urandom), 1'($urandom_range(0, 1)), 0);
    for (int i = 0; i < n_wr && !aborted; i++) begin
      run_cmd(ACT_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), pick_ack_delay());
      // a timed-out write has already put a stop on the bus
      aborted = eng_tmo;
    end
    for (int i = 0; i < n_rd && !aborted; i++)
      run_cmd(ACT_READ, 8'($urandom), 1'($urandom_range(0, 1)), 0);
    if (!aborted)
      run_cmd(ACT_STOP, 8'($urandom), 1'($urandom_range(0, 1)), 0);
  endtask

  task automatic test_random_traffic();
    int target;
    int r;
    logic [PHASE_W-1:0]   phase;
    logic [TIMEOUT_W-1:0] tmo;
    target = tick_count + RANDOM_TICKS;
    while (tick_count < target) begin
      if ($urandom_range(0, 7) == 0) begin
        r = $urandom_range(0, 15);
        if (r == 0) phase = '0;
        else if (r == 1) phase = PHASE_W'($urandom_range(5, 16));
        else phase = PHASE_W'($urandom_range(1, 4));
        tmo = ($urandom_range(0, 1) == 0) ? '0 : TIMEOUT_W'($urandom_range(1, 6));
        set_config(phase, tmo);
        // some stretches run with no gaps or stalls at all
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 4) != 0) begin
        run_transaction();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                  pick_ack_delay());
          idle_gap();
        end
      end
      idle_gap();
    end
  endtask

  // wide divider: one start command, no gaps or stalls
  task automatic test_slowest_phase();
    idle_on = 1'b0;
    set_config(SLOW_PHASE, '0);
    run_cmd(ACT_START, 8'($urandom), 1'b0, 0);
  endtask

  // ---------------------------------------------------------------------------
  // result sink: random stall bursts at the falling edge
  // ---------------------------------------------------------------------------
  initial begin
    out_res.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_res.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left    = $urandom_range(0, 15);
        out_res.ready = 1'b0;
      end else begin
        out_res.ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: each accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string fname, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in result %0d, %s: expected %0h, got %0h",
                 result_count, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_res.valid === 1'b1 && out_res.ready) begin
      got_res.scl_level    = out_res.scl_level;
      got_res.sda_pull_low = out_res.sda_pull_low;
      got_res.busy_res     = out_res.busy_res;
      got_res.done_res     = out_res.done_res;
      got_res.rx_byte      = out_res.rx_byte;
      got_res.ack_seen     = out_res.ack_seen;
      got_res.timed_out    = out_res.timed_out;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with no request outstanding", result_count);
      end else begin
        want_res = expected_results.pop_front();
        check_field("scl_level", 8'(want_res.scl_level), 8'(got_res.scl_level));
        check_field("sda_pull_low", 8'(want_res.sda_pull_low), 8'(got_res.sda_pull_low));
        check_field("busy_res", 8'(want_res.busy_res), 8'(got_res.busy_res));
        check_field("done_res", 8'(want_res.done_res), 8'(got_res.done_res));
        check_field("rx_byte", want_res.rx_byte, got_res.rx_byte);
        check_field("ack_seen", 8'(want_res.ack_seen), 8'(got_res.ack_seen));
        check_field("timed_out", 8'(want_res.timed_out), 8'(got_res.timed_out));
      end
      result_count++;
    end
  end

  // watchdog: any handshake counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_res.valid && out_res.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_req.valid    = 1'b0;
    in_req.action   = ACT_NONE;
    in_req.tx_byte  = '0;
    in_req.send_ack = 1'b0;
    in_req.sda_in   = 1'b1;
    cfg_wr.valid    = 1'b0;
    cfg_wr.index    = REG_PHASE_TICKS;
    cfg_wr.data     = '0;
    reset_engine_model();

    // synchronous reset, released at a falling edge
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_idle_ticks();
    test_bus_sequences();
    test_zero_phase();
    test_ack_timeout();
    test_random_traffic();
    test_slowest_phase();

    // drain, then wait for anything stray
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
